// ===== rtl/exact_size_block_pool_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the block pool.
// ---------------------------------------------------------------------------
`ifndef EXACT_SIZE_BLOCK_POOL_MACROS_SVH
`define EXACT_SIZE_BLOCK_POOL_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ESBP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ESBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/esbp_pkg.sv =====
// ---------------------------------------------------------------------------
// esbp_pkg
// Types and constants shared by the block pool modules.
// ---------------------------------------------------------------------------
package esbp_pkg;

   localparam int MaxEntries   = 256;
   localparam int GranuleBytes = 64;
   localparam int IdxW         = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CntW         = $clog2(MaxEntries + 1);
   localparam int GranShift    = $clog2(GranuleBytes);
   localparam int GranW        = 33 - GranShift;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RETURN  = 2'd1,
      OP_REISSUE = 2'd2,
      OP_FREE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_SPACE     = 3'd1,
      ST_UNKNOWN      = 3'd2,
      ST_NOT_HELD     = 3'd3,
      ST_ALREADY_HELD = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_CARVE,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the request
      logic scan_clr;  // restart the scan index
      logic scan_inc;  // advance the scan index
      logic hit_upd;   // update the flags of the matched entry
      logic carve;     // write a new entry at the fill count
      logic finish;    // emit the result beat
      logic fail;      // no space, or no match for a lookup
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic quick;     // request finishes without a scan
      logic scan_end;  // scan index has reached the fill count
      logic hit;       // entry under test matches
      logic can_carve; // a carve fits
   } stat_type;

endpackage

// ===== rtl/esbp_ram.sv =====
// ---------------------------------------------------------------------------
// esbp_ram
// Generic single-port-write, registered-read RAM.
// ---------------------------------------------------------------------------
module esbp_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/esbp_ctrl.sv =====
// ---------------------------------------------------------------------------
// esbp_ctrl
// Sequencer for one request: read, test each entry, then carve or finish.
// ---------------------------------------------------------------------------
`include "exact_size_block_pool_macros.svh"
module esbp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  esbp_pkg::stat_type  stat,
   output esbp_pkg::ctrl_type  ctrl
);
   import esbp_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (stat.quick) begin
               state_in = S_DONE;
            end else if (stat.scan_end) begin
               state_in = S_CARVE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.hit) begin
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_CARVE: state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctrl = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            ctrl.load     = start;
            ctrl.scan_clr = start;
         end
         S_CHECK: begin
            ctrl.hit_upd  = stat.hit;
            ctrl.scan_inc = !stat.hit;
         end
         S_CARVE: begin
            ctrl.carve = stat.can_carve;
            ctrl.fail  = !stat.can_carve;
         end
         S_DONE:  ctrl.finish = 1'b1;
         default: ctrl = '0;
      endcase
   end

   `ESBP_ASSERT_NEXT(a_done_idle, clock, reset, state_ff == S_DONE, state_ff == S_IDLE)
   `ESBP_ASSERT_IMPL(a_carve_once, clock, reset, ctrl.carve, !ctrl.hit_upd)
   `ESBP_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
endmodule

// ===== rtl/esbp_datapath.sv =====
// ---------------------------------------------------------------------------
// esbp_datapath
// Entry table, flags, scan index, carve arithmetic and result register.
// ---------------------------------------------------------------------------
`include "exact_size_block_pool_macros.svh"
module esbp_datapath (
   input  logic               clock,
   input  logic               reset,
   input  esbp_pkg::ctrl_type ctrl,
   output esbp_pkg::stat_type stat,
   input  logic [1:0]         op,
   input  logic [31:0]        req_size,
   input  logic [31:0]        block_address,
   input  logic [31:0]        pool_base,
   input  logic [31:0]        pool_capacity,
   output logic               done,
   output logic [31:0]        result_address,
   output logic [2:0]         status
);
   import esbp_pkg::*;

   op_type            op_ff;
   logic [31:0]       addr_ff;
   logic [GranW-1:0]  gran_ff;
   logic [32:0]       rounded_ff;
   logic              size_bad_ff;
   logic [CntW-1:0]   scan_ff;
   logic [CntW-1:0]   count_ff;
   logic [31:0]       carved_ff;
   logic [31:0]       res_addr_ff;
   status_type        res_st_ff;
   logic              done_ff;
   logic [IdxW-1:0]   idx_ff;

   logic [31:0]       ram_addr;
   logic [25:0]       ram_gran;
   logic [1:0]        flag_rd;
   logic [1:0]        flag_wr;
   logic              flag_we;
   logic [IdxW-1:0]   flag_idx;
   logic [IdxW-1:0]   rd_idx;
   logic [IdxW-1:0]   wr_idx;
   logic [32:0]       size_up;
   logic [32:0]       room;
   logic              ent_alive;
   logic              ent_held;
   logic [31:0]       new_addr;
   status_type        hit_st;

   assign rd_idx   = scan_ff[IdxW-1:0];
   assign wr_idx   = count_ff[IdxW-1:0];
   assign new_addr = pool_base + carved_ff;
   assign size_up  = {1'b0, req_size} + 33'(GranuleBytes - 1);

   // Entry address and size stores.
   esbp_ram #(.Width(32), .Depth(MaxEntries)) u_addr_ram (
      .clock, .wr_en(ctrl.carve), .wr_addr(wr_idx), .wr_data(new_addr),
      .rd_addr(rd_idx), .rd_data(ram_addr)
   );
   esbp_ram #(.Width(26), .Depth(MaxEntries)) u_gran_ram (
      .clock, .wr_en(ctrl.carve), .wr_addr(wr_idx),
      .wr_data(26'(gran_ff)), .rd_addr(rd_idx), .rd_data(ram_gran)
   );

   // Flag store: alive in the upper bit, held in the lower. Every entry below
   // the fill count was written when it was carved, so no clearing is needed.
   esbp_ram #(.Width(2), .Depth(MaxEntries)) u_flag_ram (
      .clock, .wr_en(flag_we), .wr_addr(flag_idx), .wr_data(flag_wr),
      .rd_addr(rd_idx), .rd_data(flag_rd)
   );

   // Flags of the entry under test, read at the scan position in step.
   assign ent_alive = flag_rd[1];
   assign ent_held  = flag_rd[0];

   // New flags for a carved entry or for the matched entry.
   always_comb begin
      flag_we  = ctrl.carve || ctrl.hit_upd;
      flag_idx = ctrl.carve ? wr_idx : idx_ff;
      flag_wr  = flag_rd;
      if (ctrl.carve) begin
         flag_wr = 2'b11;
      end else begin
         case (op_ff)
            OP_ALLOC, OP_REISSUE: flag_wr = 2'b11;
            OP_RETURN: if (ent_held) flag_wr = 2'b10;
            OP_FREE:   if (ent_held) flag_wr = 2'b00;
            default:   flag_wr = flag_rd;
         endcase
      end
   end

   // Status back to the controller.
   always_comb begin
      stat.quick    = (op_ff == OP_ALLOC) ? size_bad_ff
                                          : (op_ff == OP_FREE && addr_ff == 32'd0);
      stat.scan_end = (scan_ff >= count_ff);
      if (op_ff == OP_ALLOC) begin
         stat.hit = !ent_alive && ({7'd0, ram_gran} == 33'(gran_ff));
      end else begin
         stat.hit = ent_alive && (ram_addr == addr_ff);
      end
      room = (carved_ff > pool_capacity) ? 33'd0 : {1'b0, pool_capacity - carved_ff};
      stat.can_carve = (op_ff == OP_ALLOC) && (count_ff < CntW'(MaxEntries))
                       && (rounded_ff <= room);
   end

   // Outcome of a lookup hit.
   always_comb begin
      hit_st = ST_OK;
      case (op_ff)
         OP_REISSUE: if (ent_held) hit_st = ST_ALREADY_HELD;
         OP_RETURN, OP_FREE: if (!ent_held) hit_st = ST_NOT_HELD;
         default: hit_st = ST_OK;
      endcase
   end

   // Request capture, scan index and result register.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff       <= op_type'(op);
         addr_ff     <= block_address;
         gran_ff     <= size_up[32:GranShift];
         rounded_ff  <= {size_up[32:GranShift], GranShift'(0)};
         size_bad_ff <= (req_size == 32'd0) || (req_size > pool_capacity);
         res_addr_ff <= 32'd0;
         if (op == OP_ALLOC) begin
            res_st_ff <= ST_NO_SPACE;
         end else if (op == OP_FREE && block_address == 32'd0) begin
            res_st_ff <= ST_OK;
         end else begin
            res_st_ff <= ST_UNKNOWN;
         end
      end
      if (ctrl.scan_clr) begin
         scan_ff <= '0;
      end else if (ctrl.scan_inc) begin
         scan_ff <= scan_ff + 1'b1;
      end
      idx_ff <= rd_idx;
      if (ctrl.hit_upd) begin
         if (op_ff == OP_ALLOC) begin
            res_st_ff   <= ST_OK;
            res_addr_ff <= ram_addr;
         end else begin
            res_st_ff <= hit_st;
            if (op_ff == OP_REISSUE && hit_st == ST_OK) begin
               res_addr_ff <= ram_addr;
            end
         end
      end
      if (ctrl.carve) begin
         res_st_ff   <= ST_OK;
         res_addr_ff <= new_addr;
      end
      if (ctrl.fail && op_ff != OP_ALLOC) begin
         res_st_ff <= ST_UNKNOWN;
      end
   end

   // Fill count, carve pointer and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         carved_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= ctrl.finish;
         if (ctrl.carve) begin
            count_ff  <= count_ff + 1'b1;
            carved_ff <= carved_ff + rounded_ff[31:0];
         end
      end
   end

   assign done           = done_ff;
   assign result_address = res_addr_ff;
   assign status         = res_st_ff;

   `ESBP_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CntW'(MaxEntries))
   `ESBP_ASSERT_IMPL(a_err_zero, clock, reset, done && status != ST_OK, result_address == 32'd0)
   `ESBP_ASSERT_IMPL(a_carve_room, clock, reset, ctrl.carve, count_ff < CntW'(MaxEntries))
endmodule

// ===== rtl/exact_size_block_pool.sv =====
// Sequence from the accepting edge: READ then DONE when no scan is needed
// (alloc of a bad size, free of address zero); otherwise READ and CHECK per entry
// until a match, then DONE, or CARVE then DONE when all entries miss. The result
// beat is registered from DONE. One request at a time; the next is taken at the
// result beat's edge. The scan through registered-read memories sets the pace.
// Reset (synchronous, active high) clears fill count, carve pointer and strobe.
// ---------------------------------------------------------------------------
// exact_size_block_pool
// Size-class pool allocator carving new blocks from a bump pointer.
// ---------------------------------------------------------------------------
module exact_size_block_pool (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_size,
   input  logic [31:0] req_block_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_address,
   output logic [2:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import esbp_pkg::*;

   logic [31:0] base_ff;
   logic [31:0] cap_ff;
   ctrl_type    ctrl;
   stat_type    stat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         cap_ff  <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr == 3'd0) base_ff <= pwdata;
         if (paddr == 3'd4) cap_ff  <= pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == 3'd0) ? base_ff : (paddr == 3'd4) ? cap_ff : 32'd0;

   esbp_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .stat, .ctrl
   );

   esbp_datapath u_dp (
      .clock, .reset, .ctrl, .stat,
      .op(req_op), .req_size, .block_address(req_block_address),
      .pool_base(base_ff), .pool_capacity(cap_ff),
      .done(rsp_valid), .result_address(rsp_result_address), .status(rsp_status)
   );
endmodule
